// ===== hdl/ddm_pkg.sv =====
`timescale 1ns / 1ps

package ddm_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int SPEED_W   = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_STICK_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_CENTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_DZ     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_CENTER = 3'd6;

    localparam logic [7:0]  SERVO_LIMIT = 8'd180;
    localparam logic [24:0] SRV_DIV     = 25'd200;
    localparam logic [24:0] SRV_RECIP   = 25'd21474836;

    typedef struct packed {
        logic [7:0] throttle;
        logic [7:0] steering;
    } in_item_t;

    typedef struct packed {
        logic [7:0] left_servo;
        logic [7:0] right_servo;
    } out_item_t;

    typedef enum logic [2:0] {
        RG_IN,
        RG_TL,
        RG_TR,
        RG_BL,
        RG_BR
    } region_t;

endpackage

// ===== hdl/differential_drive_mixer_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle; the whole pipeline holds while a result waits on m_ready.
// Depth is set by the bit-serial axis dividers (16 stages) and the projection divider
// (22 + FRAC_BITS stages). Reset (aresetn low, synchronous) clears all valid bits and
// loads the register defaults: stick 0/255/128 dead zone 10, servo 0/180/90.
module differential_drive_mixer_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ddm_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ddm_pkg::out_item_t               m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ddm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                       cfg_data
);

    localparam int NW2 = 22 + FRAC_BITS;
    localparam int XW  = FRAC_BITS + 19;
    localparam int SW  = FRAC_BITS + 20;
    localparam logic signed [XW-1:0] HUND_FX = XW'(100) << FRAC_BITS;

    typedef struct packed {
        logic [15:0]       num;
        logic [8:0]        den;
        logic              neg;
        logic              zero;
        logic signed [7:0] c;
    } axis_t;

    typedef struct packed {
        logic              neg;
        logic              zero;
        logic signed [7:0] c;
    } axis_side_t;

    typedef struct packed {
        logic       valid;
        logic       rest;
        axis_side_t thr;
        axis_side_t str;
    } side1_t;

    typedef struct packed {
        logic               valid;
        logic               rest;
        ddm_pkg::region_t   region;
        logic               neg;
        logic signed [17:0] x;
        logic signed [17:0] y;
    } side2_t;

    logic [7:0] stick_min_reg;
    logic [7:0] stick_max_reg;
    logic [7:0] stick_center_reg;
    logic [6:0] stick_dz_reg;
    logic [7:0] servo_min_reg;
    logic [7:0] servo_max_reg;
    logic [7:0] servo_center_reg;

    logic en;

    axis_t  thr_next, str_next;
    axis_t  thr_reg, str_reg;
    logic   rest_a_reg;
    logic   a_valid_reg;

    logic [15:0] thr_quo, str_quo;
    side1_t      side1_in, side1_out;

    logic signed [17:0] x_next, y_next;
    logic signed [17:0] x_b_reg, y_b_reg;
    logic               rest_b_reg;
    logic               b_valid_reg;

    logic signed [19:0] xe, ye, dd;
    ddm_pkg::region_t   region_next;
    logic               kneg;
    logic [16:0]        xabs;
    logic [21:0]        kmag_next;
    logic [16:0]        dmag_next;
    ddm_pkg::region_t   region_c_reg;
    logic signed [17:0] x_c_reg, y_c_reg;
    logic [21:0]        kmag_c_reg;
    logic [16:0]        dmag_c_reg;
    logic               neg_c_reg;
    logic               rest_c_reg;
    logic               c_valid_reg;

    logic [NW2-1:0] quo2;
    side2_t         side2_in, side2_out;

    logic signed [XW-1:0] qx, xq_next, yq_next, xs, ys;
    logic signed [XW-1:0] xq_d_reg, yq_d_reg;
    logic                 rest_d_reg;
    logic                 d_valid_reg;

    logic signed [ddm_pkg::SPEED_W-1:0] left_next, right_next;
    logic signed [ddm_pkg::SPEED_W-1:0] left_e_reg, right_e_reg;
    logic                               rest_e_reg;
    logic                               e_valid_reg;

    logic [7:0] left_srv, right_srv;

    function automatic axis_t axis_prep(
        input logic [7:0] v,
        input logic [7:0] cen,
        input logic [6:0] dz,
        input logic [7:0] lo,
        input logic [7:0] hi,
        input logic       inv
    );
        logic signed [10:0] a;
        logic signed [10:0] b;
        logic signed [10:0] dv;
        logic signed [10:0] dd_l;
        logic [8:0]         mv;
        axis_t              r;
        if (v < cen) begin
            a   = signed'({3'b000, lo});
            b   = signed'({3'b000, cen}) - signed'({4'b0000, dz});
            r.c = inv ? 8'sd100 : -8'sd100;
        end else begin
            a   = signed'({3'b000, cen}) + signed'({4'b0000, dz});
            b   = signed'({3'b000, hi});
            r.c = inv ? -8'sd1 : 8'sd1;
        end
        dv     = signed'({3'b000, v}) - a;
        dd_l   = b - a;
        mv     = dv[10] ? 9'(-dv) : dv[8:0];
        r.den  = dd_l[10] ? 9'(-dd_l) : dd_l[8:0];
        r.num  = 16'(mv) * 16'd99;
        r.neg  = dv[10] ^ dd_l[10] ^ inv;
        r.zero = (dd_l == '0);
        return r;
    endfunction

    function automatic logic signed [17:0] axis_val(
        input axis_side_t  sd,
        input logic [15:0] q
    );
        logic signed [17:0] m;
        m = signed'({2'b00, q});
        if (sd.zero) begin
            return 18'(sd.c);
        end
        return (sd.neg ? -m : m) + 18'(sd.c);
    endfunction

    function automatic logic signed [ddm_pkg::SPEED_W-1:0] fix_trunc(
        input logic signed [SW-1:0] v
    );
        logic signed [SW-1:0] sh;
        sh = v >>> FRAC_BITS;
        if (v[SW-1] && (v[FRAC_BITS-1:0] != '0)) begin
            sh = sh + SW'(1);
        end
        return sh[ddm_pkg::SPEED_W-1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stick_min_reg    <= 8'd0;
            stick_max_reg    <= 8'd255;
            stick_center_reg <= 8'd128;
            stick_dz_reg     <= 7'd10;
            servo_min_reg    <= 8'd0;
            servo_max_reg    <= 8'd180;
            servo_center_reg <= 8'd90;
        end else if (cfg_valid) begin
            case (cfg_index)
                ddm_pkg::CFG_STICK_MIN:    stick_min_reg    <= cfg_data;
                ddm_pkg::CFG_STICK_MAX:    stick_max_reg    <= cfg_data;
                ddm_pkg::CFG_STICK_CENTER: stick_center_reg <= cfg_data;
                ddm_pkg::CFG_STICK_DZ:     stick_dz_reg     <= cfg_data[6:0];
                ddm_pkg::CFG_SERVO_MIN:    servo_min_reg    <= cfg_data;
                ddm_pkg::CFG_SERVO_MAX:    servo_max_reg    <= cfg_data;
                ddm_pkg::CFG_SERVO_CENTER: servo_center_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // axis offsets and spans
    always_comb begin
        thr_next = axis_prep(s_data.throttle, stick_center_reg, stick_dz_reg,
                             stick_min_reg, stick_max_reg, 1'b1);
        str_next = axis_prep(s_data.steering, stick_center_reg, stick_dz_reg,
                             stick_min_reg, stick_max_reg, 1'b0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            thr_reg    <= thr_next;
            str_reg    <= str_next;
            rest_a_reg <= (s_data.throttle == stick_center_reg) &&
                          (s_data.steering == stick_center_reg);
        end
    end

    ddm_div #(.NW(16), .DW(9)) u_div_thr (
        .aclk (aclk),
        .en   (en),
        .num  (thr_reg.num),
        .den  (thr_reg.den),
        .quo  (thr_quo)
    );

    ddm_div #(.NW(16), .DW(9)) u_div_str (
        .aclk (aclk),
        .en   (en),
        .num  (str_reg.num),
        .den  (str_reg.den),
        .quo  (str_quo)
    );

    always_comb begin
        side1_in.valid    = a_valid_reg;
        side1_in.rest     = rest_a_reg;
        side1_in.thr.neg  = thr_reg.neg;
        side1_in.thr.zero = thr_reg.zero;
        side1_in.thr.c    = thr_reg.c;
        side1_in.str.neg  = str_reg.neg;
        side1_in.str.zero = str_reg.zero;
        side1_in.str.c    = str_reg.c;
    end

    ddm_dly #(.W($bits(side1_t)), .N(16)) u_dly_axis (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d       (side1_in),
        .q       (side1_out)
    );

    always_comb begin
        x_next = axis_val(side1_out.str, str_quo);
        y_next = axis_val(side1_out.thr, thr_quo);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= side1_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_b_reg    <= x_next;
            y_b_reg    <= y_next;
            rest_b_reg <= side1_out.rest;
        end
    end

    // diamond edge region and projection operands
    always_comb begin
        xe = 20'(x_b_reg);
        ye = 20'(y_b_reg);
        if (ye > xe + 20'sd100) begin
            region_next = ddm_pkg::RG_TL;
            kneg        = 1'b1;
            dd          = xe - ye;
        end else if (ye > 20'sd100 - xe) begin
            region_next = ddm_pkg::RG_TR;
            kneg        = 1'b0;
            dd          = xe + ye;
        end else if (ye < -xe - 20'sd100) begin
            region_next = ddm_pkg::RG_BL;
            kneg        = 1'b1;
            dd          = xe + ye;
        end else if (ye < xe - 20'sd100) begin
            region_next = ddm_pkg::RG_BR;
            kneg        = 1'b0;
            dd          = xe - ye;
        end else begin
            region_next = ddm_pkg::RG_IN;
            kneg        = 1'b0;
            dd          = xe - ye;
        end
        xabs      = x_b_reg[17] ? 17'(-x_b_reg) : x_b_reg[16:0];
        kmag_next = 22'(xabs) * 22'd100;
        dmag_next = dd[19] ? 17'(-dd) : dd[16:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            region_c_reg <= region_next;
            x_c_reg      <= x_b_reg;
            y_c_reg      <= y_b_reg;
            kmag_c_reg   <= kmag_next;
            dmag_c_reg   <= dmag_next;
            neg_c_reg    <= x_b_reg[17] ^ kneg ^ dd[19];
            rest_c_reg   <= rest_b_reg;
        end
    end

    ddm_div #(.NW(NW2), .DW(17)) u_div_proj (
        .aclk (aclk),
        .en   (en),
        .num  ({kmag_c_reg, {FRAC_BITS{1'b0}}}),
        .den  (dmag_c_reg),
        .quo  (quo2)
    );

    always_comb begin
        side2_in.valid  = c_valid_reg;
        side2_in.rest   = rest_c_reg;
        side2_in.region = region_c_reg;
        side2_in.neg    = neg_c_reg;
        side2_in.x      = x_c_reg;
        side2_in.y      = y_c_reg;
    end

    ddm_dly #(.W($bits(side2_t)), .N(NW2)) u_dly_proj (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d       (side2_in),
        .q       (side2_out)
    );

    always_comb begin
        qx = signed'({2'b00, quo2[FRAC_BITS+16:0]});
        xs = XW'(side2_out.x) <<< FRAC_BITS;
        ys = XW'(side2_out.y) <<< FRAC_BITS;
        xq_next = side2_out.neg ? -qx : qx;
        case (side2_out.region)
            ddm_pkg::RG_TL: yq_next = xq_next + HUND_FX;
            ddm_pkg::RG_TR: yq_next = HUND_FX - xq_next;
            ddm_pkg::RG_BL: yq_next = -xq_next - HUND_FX;
            ddm_pkg::RG_BR: yq_next = xq_next - HUND_FX;
            ddm_pkg::RG_IN: begin
                xq_next = xs;
                yq_next = ys;
            end
            default: begin
                xq_next = xs;
                yq_next = ys;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= side2_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xq_d_reg   <= xq_next;
            yq_d_reg   <= yq_next;
            rest_d_reg <= side2_out.rest;
        end
    end

    always_comb begin
        left_next  = fix_trunc(SW'(xq_d_reg) + SW'(yq_d_reg));
        right_next = fix_trunc(SW'(yq_d_reg) - SW'(xq_d_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            left_e_reg  <= left_next;
            right_e_reg <= right_next;
            rest_e_reg  <= rest_d_reg;
        end
    end

    ddm_servo u_srv_left (
        .aclk         (aclk),
        .en           (en),
        .speed        (left_e_reg),
        .rest         (rest_e_reg),
        .servo_min    (servo_min_reg),
        .servo_max    (servo_max_reg),
        .servo_center (servo_center_reg),
        .servo        (left_srv)
    );

    ddm_servo u_srv_right (
        .aclk         (aclk),
        .en           (en),
        .speed        (right_e_reg),
        .rest         (rest_e_reg),
        .servo_min    (servo_min_reg),
        .servo_max    (servo_max_reg),
        .servo_center (servo_center_reg),
        .servo        (right_srv)
    );

    ddm_dly #(.W(1), .N(3)) u_dly_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d       (e_valid_reg),
        .q       (m_valid)
    );

    always_comb begin
        m_data.left_servo  = left_srv;
        m_data.right_servo = right_srv;
    end

`ifndef NO_ASSERTIONS
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.left_servo <= ddm_pkg::SERVO_LIMIT) &&
                    (m_data.right_servo <= ddm_pkg::SERVO_LIMIT))
        else $error("servo result above limit");

    a_edge_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_valid_reg && (region_c_reg != ddm_pkg::RG_IN)) |-> (dmag_c_reg > 17'd100))
        else $error("projection divisor too small");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(xq_d_reg) && $stable(yq_d_reg) && $stable(d_valid_reg))
        else $error("pipeline stage moved during stall");
`endif

endmodule

// ===== hdl/ddm_div.sv =====
`timescale 1ns / 1ps

module ddm_div #(
    parameter int NW = 16,
    parameter int DW = 9
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] nq_reg  [NW];
    logic [DW-1:0] den_reg [NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [NW-1:0] nq_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign nq_in  = nq_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        assign trial = {rem_in, nq_in[NW-1]};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                if (trial >= {1'b0, den_in}) begin
                    rem_reg[i] <= diff[DW-1:0];
                    nq_reg[i]  <= {nq_in[NW-2:0], 1'b1};
                end else begin
                    rem_reg[i] <= trial[DW-1:0];
                    nq_reg[i]  <= {nq_in[NW-2:0], 1'b0};
                end
                den_reg[i] <= den_in;
            end
        end
    end

    assign quo = nq_reg[NW-1];

endmodule

// ===== hdl/ddm_dly.sv =====
`timescale 1ns / 1ps

module ddm_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                pipe_reg[i] <= '0;
            end
        end else if (en) begin
            pipe_reg[0] <= d;
            for (int i = 1; i < N; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[N-1];

endmodule

// ===== hdl/ddm_servo.sv =====
`timescale 1ns / 1ps

module ddm_servo (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [ddm_pkg::SPEED_W-1:0] speed,
    input  logic                               rest,
    input  logic [7:0]                         servo_min,
    input  logic [7:0]                         servo_max,
    input  logic [7:0]                         servo_center,
    output logic [7:0]                         servo
);

    logic signed [18:0] sp;
    logic signed [8:0]  df;
    logic signed [27:0] prod1;
    logic [23:0]        mag1_next;
    logic [23:0]        mag1_reg;
    logic               neg1_reg;
    logic               rest1_reg;

    logic [48:0]        prod2;
    logic [16:0]        q0_reg;
    logic [23:0]        mag2_reg;
    logic               neg2_reg;
    logic               rest2_reg;

    logic [24:0]        rem3;
    logic [17:0]        q3;
    logic signed [19:0] qs3;
    logic signed [19:0] v3;
    logic [7:0]         servo_next;
    logic [7:0]         servo_reg;

    always_comb begin
        sp        = 19'(speed) + 19'sd100;
        df        = signed'({1'b0, servo_min}) - signed'({1'b0, servo_max});
        prod1     = 28'(sp) * 28'(df);
        mag1_next = prod1[27] ? 24'(-prod1) : prod1[23:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg  <= mag1_next;
            neg1_reg  <= prod1[27];
            rest1_reg <= rest;
        end
    end

    assign prod2 = 49'(mag1_reg) * 49'(ddm_pkg::SRV_RECIP);

    always_ff @(posedge aclk) begin
        if (en) begin
            q0_reg    <= prod2[48:32];
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            rest2_reg <= rest1_reg;
        end
    end

    always_comb begin
        rem3 = 25'(mag2_reg) - 25'(q0_reg) * ddm_pkg::SRV_DIV;
        q3   = (rem3 >= ddm_pkg::SRV_DIV) ? 18'(q0_reg) + 18'd1 : 18'(q0_reg);
        qs3  = signed'({2'b00, q3});
        v3   = (neg2_reg ? -qs3 : qs3) + signed'({12'd0, servo_max});
        if (rest2_reg) begin
            servo_next = (servo_center > ddm_pkg::SERVO_LIMIT) ? ddm_pkg::SERVO_LIMIT
                                                               : servo_center;
        end else if (v3 < 0) begin
            servo_next = 8'd0;
        end else if (v3 > 20'sd180) begin
            servo_next = ddm_pkg::SERVO_LIMIT;
        end else begin
            servo_next = v3[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            servo_reg <= servo_next;
        end
    end

    assign servo = servo_reg;

endmodule
